>>> hw/rtl/shift_xor_random_with_rolls_core_assert.svh
// Assertion macros for the generator RTL.
`ifndef SHIFT_XOR_RANDOM_WITH_ROLLS_CORE_ASSERT_SVH
`define SHIFT_XOR_RANDOM_WITH_ROLLS_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SXR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sxr: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SXR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sxr: next-cycle check failed");

`endif

>>> hw/rtl/sxr_pkg.sv
`default_nettype none

package sxr_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned OPC_W  = 3;
  localparam int unsigned THR_W  = 8;

  // Reciprocals for exact quotients of a 16-bit seed: q = (seed * M) >> S
  localparam logic [16:0] RECIP_7     = 17'd74899;
  localparam int unsigned RECIP_7_SH  = 19;
  localparam logic [16:0] RECIP_23    = 17'd91181;
  localparam int unsigned RECIP_23_SH = 21;

  localparam logic [WORD_W-1:0] PERCENT_SCALE = 16'd100;
  localparam logic [WORD_W-1:0] TABLE_MOD     = 16'd7;
  localparam logic [WORD_W-1:0] WARMUP_MOD    = 16'd23;

  typedef enum logic [OPC_W-1:0] {
    OP_RAW    = 3'd0,
    OP_SCALED = 3'd1,
    OP_PCT    = 3'd2,
    OP_ROLL   = 3'd3,
    OP_DROLL  = 3'd4,
    OP_SEED   = 3'd5,
    OP_LOAD   = 3'd6,
    OP_READ   = 3'd7
  } op_t;

  // Microprogram addresses
  typedef enum logic [4:0] {
    UPC_IDLE       = 5'd0,
    UPC_EMIT_PLAIN = 5'd1,
    UPC_RAW_DRAW   = 5'd2,
    UPC_SCL_DRAW   = 5'd3,
    UPC_SCL_EMIT   = 5'd4,
    UPC_PCT_DRAW   = 5'd5,
    UPC_PCT_EMIT   = 5'd6,
    UPC_ROLL_DRAW  = 5'd7,
    UPC_ROLL_EMIT  = 5'd8,
    UPC_DBL_DRAW_A = 5'd9,
    UPC_DBL_DRAW_B = 5'd10,
    UPC_DBL_EMIT   = 5'd11,
    UPC_SEED_Q7    = 5'd12,
    UPC_SEED_R7    = 5'd13,
    UPC_SEED_R23   = 5'd14,
    UPC_SEED_TBL   = 5'd15,
    UPC_SEED_WARM  = 5'd16,
    UPC_LOAD_WORDS = 5'd17
  } upc_t;

  // Multiplier operand select
  typedef enum logic [1:0] {
    MUL_PCT   = 2'd0,
    MUL_RANGE = 2'd1,
    MUL_M7    = 2'd2,
    MUL_M23   = 2'd3
  } mul_sel_t;

  // Scaled result select at emit
  typedef enum logic [1:0] {
    SCL_NONE = 2'd0,
    SCL_PROD = 2'd1,
    SCL_AVG  = 2'd2
  } scl_sel_t;

  typedef struct packed {
    logic     draw;    // advance the generator
    logic     raw_en;  // capture drawn value
    logic     a_en;    // capture first percent of a double roll
    mul_sel_t mul_sel;
    logic     q_en;    // capture seed quotient
    logic     k_en;    // capture seed mod 7
    logic     n_en;    // capture seed mod 23
    logic     tbl;     // load words from seed table
    logic     load;    // load words from the input word
    logic     loop;    // repeat with a draw while warm-up count is nonzero
    logic     emit;    // write the result register
    scl_sel_t scl;
    logic     hit_en;
    upc_t     next;
  } ucw_t;

  function automatic logic [WORD_W-1:0] seed_word(input logic [2:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      3'd0:    w = 16'hA36E;
      3'd1:    w = 16'h924E;
      3'd2:    w = 16'hB784;
      3'd3:    w = 16'h4F67;
      3'd4:    w = 16'h8092;
      3'd5:    w = 16'h592D;
      3'd6:    w = 16'h8E70;
      default: w = 16'hA794;
    endcase
    return w;
  endfunction

  // One generator step: value from the three words
  function automatic logic [WORD_W-1:0] gen_draw(input logic [WORD_W-1:0] w0,
                                                 input logic [WORD_W-1:0] w1,
                                                 input logic [WORD_W-1:0] w2);
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] t;
    v = (w1 << 11) + (w0 >> 5);
    t = {w2[WORD_W-2:0], w1[WORD_W-1]};
    return v ^ t;
  endfunction

  function automatic upc_t dispatch(input op_t op);
    upc_t a;
    unique case (op)
      OP_RAW:    a = UPC_RAW_DRAW;
      OP_SCALED: a = UPC_SCL_DRAW;
      OP_PCT:    a = UPC_PCT_DRAW;
      OP_ROLL:   a = UPC_ROLL_DRAW;
      OP_DROLL:  a = UPC_DBL_DRAW_A;
      OP_SEED:   a = UPC_SEED_Q7;
      OP_LOAD:   a = UPC_LOAD_WORDS;
      OP_READ:   a = UPC_EMIT_PLAIN;
    endcase
    return a;
  endfunction

  // Control store
  function automatic ucw_t ucode_rom(input upc_t pc);
    ucw_t cw;
    cw         = '0;
    cw.mul_sel = MUL_PCT;
    cw.scl     = SCL_NONE;
    cw.next    = UPC_IDLE;
    unique case (pc)
      UPC_IDLE: begin
        cw.next = UPC_IDLE;
      end
      UPC_EMIT_PLAIN: begin
        cw.emit = 1'b1;
      end
      UPC_RAW_DRAW: begin
        cw.draw = 1'b1; cw.raw_en = 1'b1; cw.next = UPC_EMIT_PLAIN;
      end
      UPC_SCL_DRAW: begin
        cw.draw = 1'b1; cw.raw_en = 1'b1; cw.next = UPC_SCL_EMIT;
      end
      UPC_SCL_EMIT: begin
        cw.emit = 1'b1; cw.mul_sel = MUL_RANGE; cw.scl = SCL_PROD;
      end
      UPC_PCT_DRAW: begin
        cw.draw = 1'b1; cw.raw_en = 1'b1; cw.next = UPC_PCT_EMIT;
      end
      UPC_PCT_EMIT: begin
        cw.emit = 1'b1; cw.scl = SCL_PROD;
      end
      UPC_ROLL_DRAW: begin
        cw.draw = 1'b1; cw.raw_en = 1'b1; cw.next = UPC_ROLL_EMIT;
      end
      UPC_ROLL_EMIT: begin
        cw.emit = 1'b1; cw.scl = SCL_PROD; cw.hit_en = 1'b1;
      end
      UPC_DBL_DRAW_A: begin
        cw.draw = 1'b1; cw.raw_en = 1'b1; cw.next = UPC_DBL_DRAW_B;
      end
      UPC_DBL_DRAW_B: begin
        cw.draw = 1'b1; cw.raw_en = 1'b1; cw.a_en = 1'b1; cw.next = UPC_DBL_EMIT;
      end
      UPC_DBL_EMIT: begin
        cw.emit = 1'b1; cw.scl = SCL_AVG; cw.hit_en = 1'b1;
      end
      UPC_SEED_Q7: begin
        cw.mul_sel = MUL_M7; cw.q_en = 1'b1; cw.next = UPC_SEED_R7;
      end
      UPC_SEED_R7: begin
        cw.mul_sel = MUL_M23; cw.q_en = 1'b1; cw.k_en = 1'b1; cw.next = UPC_SEED_R23;
      end
      UPC_SEED_R23: begin
        cw.n_en = 1'b1; cw.next = UPC_SEED_TBL;
      end
      UPC_SEED_TBL: begin
        cw.tbl = 1'b1; cw.next = UPC_SEED_WARM;
      end
      UPC_SEED_WARM: begin
        cw.loop = 1'b1; cw.next = UPC_EMIT_PLAIN;
      end
      UPC_LOAD_WORDS: begin
        cw.load = 1'b1; cw.next = UPC_EMIT_PLAIN;
      end
      default: begin
        cw.next = UPC_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sxr_in_if.sv
`default_nettype none

// Request word: opcode and operands
interface sxr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] seed;
  logic [15:0] range_max;
  logic [7:0]  threshold;
  logic [15:0] load_word0;
  logic [15:0] load_word1;
  logic [15:0] load_word2;

  modport source (
    output valid, opcode, seed, range_max, threshold,
           load_word0, load_word1, load_word2,
    input  ready
  );

  modport sink (
    input  valid, opcode, seed, range_max, threshold,
           load_word0, load_word1, load_word2,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/sxr_out_if.sv
`default_nettype none

// Result word: draws and generator state
interface sxr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_value;
  logic [15:0] scaled_value;
  logic        hit;
  logic [15:0] state_word0;
  logic [15:0] state_word1;
  logic [15:0] state_word2;

  modport source (
    output valid, raw_value, scaled_value, hit,
           state_word0, state_word1, state_word2,
    input  ready
  );

  modport sink (
    input  valid, raw_value, scaled_value, hit,
           state_word0, state_word1, state_word2,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/shift_xor_random_with_rolls_core.sv
// Shift/XOR random generator with scaled draws and percent rolls.
// din carries one request word (opcode plus operands) per valid/ready
// handshake; dout returns exactly one result word per request, in order.
// Control is a microprogram: one control word per cycle from a small
// ROM, stepped by a program counter, drives one shared 16x17 multiplier
// and the three 16-bit generator words.
// Seed requests end in a warm-up loop of (seed mod 23) draws, drawing once
// per cycle. A new request is taken only while the sequencer is idle.
// The result register is separate from the sequencer: a request is
// accepted while the previous result still waits on dout. If dout stalls,
// the next request halts at its emit step until the old result is taken.
// Reset (synchronous, active high) returns the generator to the seed-zero
// words A36E, 924E, B784, empties the result register and idles.
`default_nettype none

`include "shift_xor_random_with_rolls_core_assert.svh"

module shift_xor_random_with_rolls_core (
  input  wire logic clk,
  input  wire logic rst,
  sxr_in_if.sink    din,
  sxr_out_if.source dout
);

  sxr_pkg::upc_t pc;
  sxr_pkg::upc_t pc_next;
  sxr_pkg::ucw_t cw;

  // Generator words
  logic [15:0] w0;
  logic [15:0] w1;
  logic [15:0] w2;

  // Latched operands
  logic [15:0] seed_q;
  logic [15:0] range_q;
  logic [7:0]  thr_q;
  logic [15:0] ld0_q;
  logic [15:0] ld1_q;
  logic [15:0] ld2_q;

  // Working registers
  logic [15:0] raw_q;
  logic [6:0]  pct_a;
  logic [13:0] q;
  logic [2:0]  k;
  logic [4:0]  n;

  // Result register
  logic        out_valid;
  logic [15:0] out_raw;
  logic [15:0] out_scaled;
  logic        out_hit;
  logic [15:0] out_w0;
  logic [15:0] out_w1;
  logic [15:0] out_w2;

  logic        in_fire;
  logic        out_busy;
  logic        draw_en;
  logic        emit_fire;
  logic [15:0] draw_val;
  logic [15:0] mul_a;
  logic [16:0] mul_b;
  logic [32:0] prod;
  logic [15:0] scaled_val;
  logic [7:0]  avg_sum;
  logic        hit_val;
  logic [15:0] rem7;
  logic [15:0] rem23;

  assign din.ready = (pc == sxr_pkg::UPC_IDLE);
  assign in_fire   = din.valid && din.ready;
  assign out_busy  = out_valid && !dout.ready;

  // Control decode
  always_comb begin
    cw        = sxr_pkg::ucode_rom(pc);
    draw_en   = cw.draw || (cw.loop && (n != 5'd0));
    emit_fire = cw.emit && !out_busy;
  end

  // Sequencer: dispatch, emit stall, warm-up loop
  always_comb begin
    pc_next = pc;
    if (pc == sxr_pkg::UPC_IDLE) begin
      if (in_fire) begin
        pc_next = sxr_pkg::dispatch(sxr_pkg::op_t'(din.opcode));
      end
    end else if (cw.emit) begin
      if (!out_busy) begin
        pc_next = cw.next;
      end
    end else if (cw.loop) begin
      if (n == 5'd0) begin
        pc_next = cw.next;
      end
    end else begin
      pc_next = cw.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= sxr_pkg::UPC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Shared multiplier: scaling, percent and seed reciprocals
  always_comb begin
    mul_a = raw_q;
    mul_b = {1'b0, sxr_pkg::PERCENT_SCALE};
    case (cw.mul_sel)
      sxr_pkg::MUL_RANGE: mul_b = {1'b0, range_q};
      sxr_pkg::MUL_M7: begin
        mul_a = seed_q;
        mul_b = sxr_pkg::RECIP_7;
      end
      sxr_pkg::MUL_M23: begin
        mul_a = seed_q;
        mul_b = sxr_pkg::RECIP_23;
      end
      default: mul_b = {1'b0, sxr_pkg::PERCENT_SCALE};
    endcase
    prod = {17'd0, mul_a} * {16'd0, mul_b};
  end

  assign draw_val = sxr_pkg::gen_draw(w0, w1, w2);

  // Remainders from the registered quotient
  assign rem7  = seed_q - 16'({2'b00, q} * sxr_pkg::TABLE_MOD);
  assign rem23 = seed_q - 16'({2'b00, q} * sxr_pkg::WARMUP_MOD);

  // Result fields at the emit step
  always_comb begin
    avg_sum = {1'b0, pct_a} + {1'b0, prod[22:16]};
    case (cw.scl)
      sxr_pkg::SCL_PROD: scaled_val = prod[31:16];
      sxr_pkg::SCL_AVG:  scaled_val = {9'd0, avg_sum[7:1]};
      default:           scaled_val = 16'd0;
    endcase
    hit_val = cw.hit_en && ({8'd0, thr_q} > scaled_val);
  end

  // Generator words
  always_ff @(posedge clk) begin
    if (rst) begin
      w0 <= sxr_pkg::seed_word(3'd0);
      w1 <= sxr_pkg::seed_word(3'd1);
      w2 <= sxr_pkg::seed_word(3'd2);
    end else if (cw.load) begin
      w0 <= ld0_q;
      w1 <= ld1_q;
      w2 <= ld2_q;
    end else if (cw.tbl) begin
      w0 <= sxr_pkg::seed_word(k);
      w1 <= sxr_pkg::seed_word(k + 3'd1);
      w2 <= sxr_pkg::seed_word(k + 3'd2);
    end else if (draw_en) begin
      w0 <= draw_val;
      w1 <= w0;
      w2 <= w1;
    end
  end

  // Operand capture and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      seed_q  <= din.seed;
      range_q <= din.range_max;
      thr_q   <= din.threshold;
      ld0_q   <= din.load_word0;
      ld1_q   <= din.load_word1;
      ld2_q   <= din.load_word2;
      raw_q   <= 16'd0;
    end else if (cw.raw_en) begin
      raw_q <= draw_val;
    end
    if (cw.a_en) begin
      pct_a <= prod[22:16];
    end
    if (cw.q_en) begin
      if (cw.mul_sel == sxr_pkg::MUL_M7) begin
        q <= 14'(prod >> sxr_pkg::RECIP_7_SH);
      end else begin
        q <= 14'(prod >> sxr_pkg::RECIP_23_SH);
      end
    end
    if (cw.k_en) begin
      k <= rem7[2:0];
    end
    if (cw.n_en) begin
      n <= rem23[4:0];
    end else if (cw.loop && (n != 5'd0)) begin
      n <= n - 5'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_raw    <= raw_q;
      out_scaled <= scaled_val;
      out_hit    <= hit_val;
      out_w0     <= w0;
      out_w1     <= w1;
      out_w2     <= w2;
    end
  end

  assign dout.valid        = out_valid;
  assign dout.raw_value    = out_raw;
  assign dout.scaled_value = out_scaled;
  assign dout.hit          = out_hit;
  assign dout.state_word0  = out_w0;
  assign dout.state_word1  = out_w1;
  assign dout.state_word2  = out_w2;

  // Checks
  `SXR_ASSERT_NEXT(a_warm_exit, clk, rst, (pc == sxr_pkg::UPC_SEED_WARM) && (n == 5'd0), pc == sxr_pkg::UPC_EMIT_PLAIN)
  `SXR_ASSERT_NEXT(a_k_range, clk, rst, pc == sxr_pkg::UPC_SEED_R7, k <= 3'd6)
  `SXR_ASSERT_NEXT(a_n_range, clk, rst, pc == sxr_pkg::UPC_SEED_R23, n <= 5'd22)
  `SXR_ASSERT_NEXT(a_emit_state, clk, rst, emit_fire, dout.valid && (dout.state_word0 == w0))

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CLK_HALF   = 10;
  localparam int unsigned LIMIT      = 400000;
  localparam int unsigned HOLD_AT    = 260;   // results seen before the long sink stall
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned CALM_TAIL  = 150;   // last words go with no idling
  localparam int unsigned N_RANDOM   = 930;
  localparam int unsigned SETTLE     = 40;

  localparam logic [15:0] SEED_TAB [8] = '{
    16'hA36E, 16'h924E, 16'hB784, 16'h4F67, 16'h8092, 16'h592D, 16'h8E70, 16'hA794
  };

  typedef struct packed {
    sxr_pkg::op_t op;
    logic [15:0]  seed;
    logic [15:0]  range_max;
    logic [7:0]   threshold;
    logic [15:0]  lw0;
    logic [15:0]  lw1;
    logic [15:0]  lw2;
    logic         drain_first;   // hold this word back until all results are in
  } request_t;

  typedef struct packed {
    logic [15:0] raw;
    logic [15:0] scaled;
    logic        hit;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
  } draw_result_t;

  logic clk;
  logic rst;

  sxr_in_if  din_if ();
  sxr_out_if dout_if ();

  shift_xor_random_with_rolls_core u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  // Generator words as the block should hold them
  logic [15:0] gen_w0, gen_w1, gen_w2;

  request_t     request_q [$];
  draw_result_t expected_draws [$];
  request_t     cur_req;

  int unsigned n_sent, n_recv, n_err, total_items, cycles;
  int unsigned op_seen [8];
  int unsigned hit_count;
  int unsigned gap_left, stall_left, hold_left;
  logic        hold_done;
  logic        offer, take;

  always #CLK_HALF clk = ~clk;

  // One shift/XOR step of the generator
  function automatic logic [15:0] advance_generator();
    logic [15:0] v;
    v = (gen_w1 << 11) + (gen_w0 >> 5);
    v = v ^ {gen_w2[14:0], gen_w1[15]};
    gen_w2 = gen_w1;
    gen_w1 = gen_w0;
    gen_w0 = v;
    return v;
  endfunction

  function automatic logic [15:0] scale_draw(input logic [15:0] raw, input logic [15:0] span);
    logic [31:0] p;
    p = raw * span;
    return p[31:16];
  endfunction

  // Expected result of one request; updates the generator words
  function automatic draw_result_t apply_request(input request_t r);
    draw_result_t res;
    logic [15:0]  first;
    int unsigned  k, n;
    res = '0;
    case (r.op)
      sxr_pkg::OP_RAW: res.raw = advance_generator();
      sxr_pkg::OP_SCALED: begin
        res.raw    = advance_generator();
        res.scaled = scale_draw(res.raw, r.range_max);
      end
      sxr_pkg::OP_PCT: begin
        res.raw    = advance_generator();
        res.scaled = scale_draw(res.raw, 16'd100);
      end
      sxr_pkg::OP_ROLL: begin
        res.raw    = advance_generator();
        res.scaled = scale_draw(res.raw, 16'd100);
        res.hit    = ({8'd0, r.threshold} > res.scaled);
      end
      sxr_pkg::OP_DROLL: begin
        first      = scale_draw(advance_generator(), 16'd100);
        res.raw    = advance_generator();
        res.scaled = (first + scale_draw(res.raw, 16'd100)) >> 1;
        res.hit    = ({8'd0, r.threshold} > res.scaled);
      end
      sxr_pkg::OP_SEED: begin
        k = r.seed % 7;
        n = r.seed % 23;
        gen_w0 = SEED_TAB[k];
        gen_w1 = SEED_TAB[(k + 1) % 8];
        gen_w2 = SEED_TAB[(k + 2) % 8];
        for (int i = 0; i < n; i++) void'(advance_generator());
      end
      sxr_pkg::OP_LOAD: begin
        gen_w0 = r.lw0;
        gen_w1 = r.lw1;
        gen_w2 = r.lw2;
      end
      default: ;
    endcase
    res.w0 = gen_w0;
    res.w1 = gen_w1;
    res.w2 = gen_w2;
    return res;
  endfunction

  // Random request of a given opcode; every field gets full-range content
  function automatic request_t make_req(input sxr_pkg::op_t op);
    request_t r;
    r.op          = op;
    r.seed        = 16'($urandom_range(0, 65535));
    r.range_max   = 16'($urandom_range(0, 65535));
    r.threshold   = 8'($urandom_range(0, 255));
    r.lw0         = 16'($urandom_range(0, 65535));
    r.lw1         = 16'($urandom_range(0, 65535));
    r.lw2         = 16'($urandom_range(0, 65535));
    r.drain_first = 1'b0;
    return r;
  endfunction

  function automatic sxr_pkg::op_t pick_op();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 14)      return sxr_pkg::OP_RAW;
    else if (p < 30) return sxr_pkg::OP_SCALED;
    else if (p < 44) return sxr_pkg::OP_PCT;
    else if (p < 62) return sxr_pkg::OP_ROLL;
    else if (p < 80) return sxr_pkg::OP_DROLL;
    else if (p < 86) return sxr_pkg::OP_SEED;
    else if (p < 92) return sxr_pkg::OP_LOAD;
    else             return sxr_pkg::OP_READ;
  endfunction

  function automatic logic idle_ok(input int unsigned n);
    return (n + CALM_TAIL < total_items) && ((n / 120) % 3 != 1);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at result %0d: %s got %h want %h", n_recv, what, got, want);
    n_err++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Driver: offers queued words, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      din_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      offer = din_if.valid;
      if (din_if.valid && din_if.ready) begin
        expected_draws.push_back(apply_request(cur_req));
        op_seen[cur_req.op]++;
        n_sent++;
        offer = 1'b0;
        if (idle_ok(n_sent) && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 17);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].drain_first && n_sent != n_recv)) begin
          cur_req = request_q.pop_front();
          offer   = 1'b1;
          din_if.opcode     <= cur_req.op;
          din_if.seed       <= cur_req.seed;
          din_if.range_max  <= cur_req.range_max;
          din_if.threshold  <= cur_req.threshold;
          din_if.load_word0 <= cur_req.lw0;
          din_if.load_word1 <= cur_req.lw1;
          din_if.load_word2 <= cur_req.lw2;
        end
      end
      din_if.valid <= offer;
    end
  end

  // Sink ready: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      take = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (!hold_done && n_recv >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        take      = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (idle_ok(n_recv) && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        take       = 1'b0;
      end
      dout_if.ready <= take;
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    draw_result_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (expected_draws.size() == 0) begin
        $display("unexpected result word %0d", n_recv);
        n_err++;
      end else begin
        want = expected_draws.pop_front();
        check_field("raw_value", dout_if.raw_value, want.raw);
        check_field("scaled_value", dout_if.scaled_value, want.scaled);
        check_field("hit", {15'd0, dout_if.hit}, {15'd0, want.hit});
        check_field("state_word0", dout_if.state_word0, want.w0);
        check_field("state_word1", dout_if.state_word1, want.w1);
        check_field("state_word2", dout_if.state_word2, want.w2);
        if (dout_if.hit) hit_count++;
      end
      n_recv <= n_recv + 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results", cycles, n_recv, n_sent);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    request_t r;
    clk = 1'b0;
    rst = 1'b1;
    cycles = 0;
    n_sent = 0;
    n_recv = 0;
    n_err  = 0;
    hit_count = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    din_if.valid      = 1'b0;
    din_if.opcode     = sxr_pkg::OP_READ;
    din_if.seed       = '0;
    din_if.range_max  = '0;
    din_if.threshold  = '0;
    din_if.load_word0 = '0;
    din_if.load_word1 = '0;
    din_if.load_word2 = '0;
    dout_if.ready     = 1'b0;
    gen_w0 = SEED_TAB[0];
    gen_w1 = SEED_TAB[1];
    gen_w2 = SEED_TAB[2];

    // Directed: reset state, field extremes, every opcode, seeding corners
    request_q.push_back(make_req(sxr_pkg::OP_READ));
    request_q.push_back(make_req(sxr_pkg::OP_RAW));
    r = make_req(sxr_pkg::OP_SCALED); r.range_max = 16'd0;    request_q.push_back(r);
    r = make_req(sxr_pkg::OP_SCALED); r.range_max = 16'd1;    request_q.push_back(r);
    r = make_req(sxr_pkg::OP_SCALED); r.range_max = 16'hFFFF; request_q.push_back(r);
    request_q.push_back(make_req(sxr_pkg::OP_PCT));
    r = make_req(sxr_pkg::OP_ROLL);  r.threshold = 8'd0;      request_q.push_back(r);
    r = make_req(sxr_pkg::OP_ROLL);  r.threshold = 8'd255;    request_q.push_back(r);
    r = make_req(sxr_pkg::OP_DROLL); r.threshold = 8'd0;      request_q.push_back(r);
    r = make_req(sxr_pkg::OP_DROLL); r.threshold = 8'd255;    request_q.push_back(r);
    r = make_req(sxr_pkg::OP_DROLL); r.threshold = 8'd50;     request_q.push_back(r);
    r = make_req(sxr_pkg::OP_SEED);  r.seed = 16'd0;          request_q.push_back(r);
    r = make_req(sxr_pkg::OP_SEED);  r.seed = 16'hFFFF;       request_q.push_back(r);
    r = make_req(sxr_pkg::OP_SEED);  r.seed = 16'd22;         request_q.push_back(r);  // longest warm-up
    r = make_req(sxr_pkg::OP_SEED);  r.seed = 16'd6;          request_q.push_back(r);  // table wraps
    r = make_req(sxr_pkg::OP_SEED);  r.seed = 16'd5;          request_q.push_back(r);
    r = make_req(sxr_pkg::OP_LOAD);  r.lw0 = '0; r.lw1 = '0; r.lw2 = '0;
    request_q.push_back(r);
    request_q.push_back(make_req(sxr_pkg::OP_RAW));                                    // zero state sticks
    r = make_req(sxr_pkg::OP_DROLL); r.threshold = 8'd1;      request_q.push_back(r);
    r = make_req(sxr_pkg::OP_LOAD);  r.lw0 = '1; r.lw1 = '1; r.lw2 = '1;
    request_q.push_back(r);
    r = make_req(sxr_pkg::OP_SCALED); r.range_max = 16'hFFFF; request_q.push_back(r);
    r = make_req(sxr_pkg::OP_READ);  r.drain_first = 1'b1;    request_q.push_back(r);
    r = make_req(sxr_pkg::OP_LOAD);  r.lw0 = 16'h5555; r.lw1 = 16'hAAAA; r.lw2 = 16'h8000;
    request_q.push_back(r);
    r = make_req(sxr_pkg::OP_ROLL);  r.threshold = 8'd100;    request_q.push_back(r);

    // Random: weighted opcodes, thresholds often near the percent range
    for (int i = 0; i < N_RANDOM; i++) begin
      r = make_req(pick_op());
      if ($urandom_range(0, 1) == 0) r.threshold = 8'($urandom_range(0, 101));
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       r.range_max = 16'd0;
          1:       r.range_max = 16'd1;
          2:       r.range_max = 16'd100;
          default: r.range_max = 16'hFFFF;
        endcase
      end
      if (r.op == sxr_pkg::OP_LOAD && $urandom_range(0, 9) == 0) begin
        r.lw0 = '0; r.lw1 = '0; r.lw2 = '0;
      end
      r.drain_first = (i == N_RANDOM / 2) || ($urandom_range(0, 59) == 0);
      request_q.push_back(r);
    end
    total_items = request_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, every result back, then settle
    do @(negedge clk);
    while (request_q.size() != 0 || din_if.valid || n_recv != n_sent);
    repeat (SETTLE) @(negedge clk);
    while (expected_draws.size() != 0) begin
      void'(expected_draws.pop_front());
      $display("result never arrived");
      n_err++;
    end

    $display("covered %0d requests: raw %0d scaled %0d pct %0d roll %0d droll %0d",
             n_sent, op_seen[sxr_pkg::OP_RAW], op_seen[sxr_pkg::OP_SCALED],
             op_seen[sxr_pkg::OP_PCT], op_seen[sxr_pkg::OP_ROLL],
             op_seen[sxr_pkg::OP_DROLL]);
    $display("  seed %0d load %0d read %0d, %0d hits, %0d mismatches, %0d cycles",
             op_seen[sxr_pkg::OP_SEED], op_seen[sxr_pkg::OP_LOAD],
             op_seen[sxr_pkg::OP_READ], hit_count, n_err, cycles);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
